// ----- sv/tcce_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types, widths and codes of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int OP_W    = 2;
    localparam int POS_W   = 12;
    localparam int DIM_W   = 13;
    localparam int CFG_IDX_W = 1;

    // Working width of the cursor math: holds a position plus a few cell steps
    localparam int CALC_W  = POS_W + 2;

    // Largest usable screen dimension
    localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(4096);

    // Tab stops
    localparam int TAB_STEP = 32;

    // Default cell geometry
    localparam int CELL_WIDTH_DEF  = 8;
    localparam int CELL_HEIGHT_DEF = 16;

    // Register reset values
    localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = DIM_W'(480);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

    // Draw operations
    localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
    localparam logic [OP_W-1:0] OP_GLYPH = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Effective screen size, capped
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_dims;

    // Cursor position
    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } t_cursor;

    // One draw command
    typedef struct packed {
        logic [OP_W-1:0]   draw_op;
        logic [POS_W-1:0]  cell_x;
        logic [POS_W-1:0]  cell_y;
        logic [CHAR_W-1:0] glyph_code;
        logic              scroll_up;
    } t_draw;

endpackage
`default_nettype wire

// ----- sv/tcce_ifs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_ifs
// Handshake channels: character input, draw command output, register writes.
// ----------------------------------------------------------------------------
interface tcce_char_if
    import tcce_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface tcce_draw_if
    import tcce_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   draw_op;
    logic [POS_W-1:0]  cell_x;
    logic [POS_W-1:0]  cell_y;
    logic [CHAR_W-1:0] glyph_code;
    logic              scroll_up;

    modport source (output valid, output draw_op, output cell_x, output cell_y,
                    output glyph_code, output scroll_up, input ready);
    modport sink   (input valid, input draw_op, input cell_x, input cell_y,
                    input glyph_code, input scroll_up, output ready);
endinterface

interface tcce_cfg_if
    import tcce_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/tcce_cfg_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_cfg_regs
// Screen size registers; presents the sizes capped to the largest usable value.
// ----------------------------------------------------------------------------
module tcce_cfg_regs
    import tcce_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    tcce_cfg_if.sink       i_cfg,
    output t_dims          o_dims
);

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic             cfg_write;

    // Always take a word
    assign i_cfg.ready = 1'b1;
    assign cfg_write   = i_cfg.valid;

    // Decode the register index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SCREEN_WIDTH_RST;
            r_height <= SCREEN_HEIGHT_RST;
        end else if (cfg_write) begin
            unique case (i_cfg.index)
                CFG_SCREEN_WIDTH:  r_width  <= i_cfg.data;
                CFG_SCREEN_HEIGHT: r_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Clamp oversized dimensions
    assign o_dims.width  = (r_width  > DIM_CAP) ? DIM_CAP : r_width;
    assign o_dims.height = (r_height > DIM_CAP) ? DIM_CAP : r_height;

endmodule
`default_nettype wire

// ----- sv/tcce_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_step
// Cursor update for one character: control handling, line wrap and scroll.
// ----------------------------------------------------------------------------
module tcce_step
    import tcce_pkg::*;
#(
    parameter int CELL_WIDTH  = CELL_WIDTH_DEF,
    parameter int CELL_HEIGHT = CELL_HEIGHT_DEF
) (
    input  wire logic [CHAR_W-1:0] i_char_code,
    input  wire t_cursor           i_cursor,
    input  wire t_dims             i_dims,
    output t_cursor                o_cursor,
    output t_draw                  o_draw
);

    localparam logic [CALC_W-1:0] CW       = CALC_W'(CELL_WIDTH);
    localparam logic [CALC_W-1:0] CH       = CALC_W'(CELL_HEIGHT);
    localparam logic [CALC_W-1:0] TAB_ADD  = CALC_W'(TAB_STEP);
    localparam logic [CALC_W-1:0] TAB_MASK = ~CALC_W'(TAB_STEP - 1);

    logic [CALC_W-1:0] col0;
    logic [CALC_W-1:0] row0;
    logic [CALC_W-1:0] col_a;
    logic [CALC_W-1:0] row_a;
    logic [CALC_W-1:0] col_b;
    logic [CALC_W-1:0] row_b;
    logic [CALC_W-1:0] row_c;
    logic              scroll;
    t_draw             draw;

    assign col0 = CALC_W'(i_cursor.col);
    assign row0 = CALC_W'(i_cursor.row);

    // Handle the character itself
    always_comb begin
        col_a = col0;
        row_a = row0;
        draw  = '0;
        unique case (i_char_code)
            CH_NEWLINE: begin
                col_a = '0;
                row_a = row0 + CH;
            end
            CH_RETURN: begin
                col_a = '0;
            end
            CH_TAB: begin
                col_a = (col0 + TAB_ADD) & TAB_MASK;
            end
            CH_BACKSPACE: begin
                if (col0 >= CW) begin
                    col_a        = col0 - CW;
                    draw.draw_op = OP_CLEAR;
                    draw.cell_x  = POS_W'(col0 - CW);
                    draw.cell_y  = i_cursor.row;
                end
            end
            default: begin
                draw.draw_op    = OP_GLYPH;
                draw.cell_x     = i_cursor.col;
                draw.cell_y     = i_cursor.row;
                draw.glyph_code = i_char_code;
                col_a           = col0 + CW;
            end
        endcase
    end

    // Wrap when the next cell would pass the width
    always_comb begin
        if (col_a + CW > CALC_W'(i_dims.width)) begin
            col_b = '0;
            row_b = row_a + CH;
        end else begin
            col_b = col_a;
            row_b = row_a;
        end
    end

    // Scroll when the line would pass the height; saturate at the top
    assign scroll = (row_b + CH > CALC_W'(i_dims.height));

    always_comb begin
        if (!scroll) begin
            row_c = row_b;
        end else if (row_b >= CH) begin
            row_c = row_b - CH;
        end else begin
            row_c = '0;
        end
    end

    assign o_cursor.col = col_b[POS_W-1:0];
    assign o_cursor.row = row_c[POS_W-1:0];

    always_comb begin
        o_draw           = draw;
        o_draw.scroll_up = scroll;
    end

endmodule
`default_nettype wire

// ----- sv/text_console_cursor_engine_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit
// Character stream to draw commands for a text console blitter.
// ----------------------------------------------------------------------------
// The engine takes one character byte per clock and returns exactly one draw
// command per character, in order. A character passes an input register, the
// cursor update logic and a result register that offers its command to the
// sink; the cursor register is updated in the same cycle the command is
// loaded into the result register, so back-to-back characters see each
// other's cursor. Throughput is one character per cycle for as long as the
// command sink keeps ready high; when it stalls, one more character is held
// in the input register before ready drops. Screen size writes are taken at
// any time and must only be issued while no character is in flight.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_unit
    import tcce_pkg::*;
#(
    parameter int CELL_WIDTH  = CELL_WIDTH_DEF,
    parameter int CELL_HEIGHT = CELL_HEIGHT_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcce_char_if.sink i_char,
    tcce_cfg_if.sink  i_cfg,
    tcce_draw_if.source o_draw
);

    t_dims             dims;
    t_cursor           r_cursor;
    t_cursor           n_cursor;
    t_draw             n_draw;
    t_draw             r_draw;
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_out_valid;
    logic              advance;

    tcce_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_dims  (dims)
    );

    tcce_step #(
        .CELL_WIDTH  (CELL_WIDTH),
        .CELL_HEIGHT (CELL_HEIGHT)
    ) u_step (
        .i_char_code (r_in_char),
        .i_cursor    (r_cursor),
        .i_dims      (dims),
        .o_cursor    (n_cursor),
        .o_draw      (n_draw)
    );

    // Move the held word on when the result register is free
    assign advance      = !r_out_valid || o_draw.ready;
    assign i_char.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_char <= i_char.char_code;
        end
    end

    // Cursor and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_cursor <= n_cursor;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_draw <= n_draw;
        end
    end

    // Drive the command channel
    assign o_draw.valid      = r_out_valid;
    assign o_draw.draw_op    = r_draw.draw_op;
    assign o_draw.cell_x     = r_draw.cell_x;
    assign o_draw.cell_y     = r_draw.cell_y;
    assign o_draw.glyph_code = r_draw.glyph_code;
    assign o_draw.scroll_up  = r_draw.scroll_up;

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds character words and screen size writes into the cursor engine. Each
// accepted character goes through a local cursor predictor, and every
// returned draw command is checked field by field against the oldest
// prediction. Both channels idle and stall at random. Screen sizes change
// only between phases, once no command is outstanding.
// ----------------------------------------------------------------------------
module testbench;
    import tcce_pkg::*;

    localparam int CELL_W       = CELL_WIDTH_DEF;
    localparam int CELL_H       = CELL_HEIGHT_DEF;
    localparam int RANDOM_WORDS = 800;
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk;
    logic i_rst_n;

    tcce_char_if char_ch ();
    tcce_cfg_if  cfg_ch ();
    tcce_draw_if draw_ch ();

    text_console_cursor_engine_unit #(
        .CELL_WIDTH  (CELL_W),
        .CELL_HEIGHT (CELL_H)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_ch),
        .i_cfg   (cfg_ch),
        .o_draw  (draw_ch)
    );

    // Predicted screen size and cursor
    logic [DIM_W-1:0] screen_w = SCREEN_WIDTH_RST;
    logic [DIM_W-1:0] screen_h = SCREEN_HEIGHT_RST;
    logic [POS_W-1:0] cur_col  = '0;
    logic [POS_W-1:0] cur_row  = '0;

    // Characters waiting to be sent, commands waiting to come back
    logic [CHAR_W-1:0] chars_pending[$];
    t_draw             draws_due[$];

    int          mismatches    = 0;
    int          cmds_seen     = 0;
    int          chars_taken   = 0;
    int          settings_used = 1;
    int          glyphs        = 0;
    int          clears        = 0;
    int          scrolls       = 0;
    int          char_gap      = 0;
    int          draw_stall    = 0;
    bit          steady        = 1'b0;
    int unsigned cycles        = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 96) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Character mix: control codes often enough to move the cursor around
    function automatic logic [CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return CH_NEWLINE;
        if (r < 15) return CH_RETURN;
        if (r < 23) return CH_TAB;
        if (r < 33) return CH_BACKSPACE;
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // Screen dimension: small ones for frequent wraps and scrolls, some oversized
    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return DIM_W'($urandom_range(0, 31));
        if (r < 60) return DIM_W'($urandom_range(32, 400));
        if (r < 90) return DIM_W'($urandom_range(401, 4096));
        return DIM_W'($urandom_range(4097, 8191));
    endfunction

    // Advance the cursor by one character and return the draw command it gives
    function automatic t_draw next_draw(input logic [CHAR_W-1:0] ch);
        int unsigned col;
        int unsigned row;
        int unsigned w;
        int unsigned h;
        t_draw       d;
        d   = '0;
        col = cur_col;
        row = cur_row;
        w   = (screen_w > DIM_CAP) ? DIM_CAP : screen_w;
        h   = (screen_h > DIM_CAP) ? DIM_CAP : screen_h;

        case (ch)
            CH_NEWLINE: begin
                col = 0;
                row += CELL_H;
            end
            CH_RETURN: begin
                col = 0;
            end
            CH_TAB: begin
                col = (col + TAB_STEP) / TAB_STEP * TAB_STEP;
            end
            CH_BACKSPACE: begin
                // nothing to erase left of the first cell
                if (col >= CELL_W) begin
                    col -= CELL_W;
                    d.draw_op = OP_CLEAR;
                    d.cell_x  = POS_W'(col);
                    d.cell_y  = POS_W'(row);
                end
            end
            default: begin
                d.draw_op    = OP_GLYPH;
                d.cell_x     = POS_W'(col);
                d.cell_y     = POS_W'(row);
                d.glyph_code = ch;
                col += CELL_W;
            end
        endcase

        // wrap once, then scroll once, with the row held at zero on tiny screens
        if (col + CELL_W > w) begin
            col = 0;
            row += CELL_H;
        end
        if (row + CELL_H > h) begin
            d.scroll_up = 1'b1;
            row = (row >= CELL_H) ? row - CELL_H : 0;
        end

        cur_col = POS_W'(col);
        cur_row = POS_W'(row);
        return d;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch at command %0d: %s got %0d, expected %0d",
                 cmds_seen, what, got, want);
    endtask

    // Compare one returned command with the oldest prediction
    task automatic check_draw();
        t_draw want;
        cmds_seen++;
        if (draws_due.size() == 0) begin
            report_mismatch("command with none pending, draw_op", draw_ch.draw_op, -1);
            return;
        end
        want = draws_due.pop_front();
        if (want.draw_op == OP_GLYPH) glyphs++;
        if (want.draw_op == OP_CLEAR) clears++;
        if (want.scroll_up) scrolls++;
        if (draw_ch.draw_op !== want.draw_op)
            report_mismatch("draw_op", draw_ch.draw_op, want.draw_op);
        if (draw_ch.cell_x !== want.cell_x)
            report_mismatch("cell_x", draw_ch.cell_x, want.cell_x);
        if (draw_ch.cell_y !== want.cell_y)
            report_mismatch("cell_y", draw_ch.cell_y, want.cell_y);
        if (draw_ch.glyph_code !== want.glyph_code)
            report_mismatch("glyph_code", draw_ch.glyph_code, want.glyph_code);
        if (draw_ch.scroll_up !== want.scroll_up)
            report_mismatch("scroll_up", draw_ch.scroll_up, want.scroll_up);
    endtask

    // Character driver: predict on accept, then offer the next word after a gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            char_ch.valid     <= 1'b0;
            char_ch.char_code <= '0;
            char_gap = idle_len();
        end else begin
            if (char_ch.valid && char_ch.ready) begin
                draws_due.push_back(next_draw(char_ch.char_code));
                chars_taken++;
            end
            if (!char_ch.valid || char_ch.ready) begin
                if (chars_pending.size() > 0 && (steady || char_gap == 0)) begin
                    char_ch.valid     <= 1'b1;
                    char_ch.char_code <= chars_pending.pop_front();
                    char_gap = steady ? 0 : idle_len();
                end else begin
                    char_ch.valid <= 1'b0;
                    if (char_gap > 0) char_gap--;
                end
            end
        end
    end

    // Command monitor: check on accept, stall ready at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            draw_ch.ready <= 1'b0;
            draw_stall = 0;
        end else begin
            if (draw_ch.valid && draw_ch.ready) check_draw();
            if (draw_stall > 0 && !steady) begin
                draw_ch.ready <= 1'b0;
                draw_stall--;
            end else begin
                draw_ch.ready <= 1'b1;
                draw_stall = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d commands outstanding",
                     cycles, draws_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Write one screen size register; the predictor takes it on accept
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == CFG_SCREEN_WIDTH) screen_w = value;
        else screen_h = value;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_screen(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_SCREEN_WIDTH, w);
            write_reg(CFG_SCREEN_HEIGHT, h);
        end else begin
            write_reg(CFG_SCREEN_HEIGHT, h);
            write_reg(CFG_SCREEN_WIDTH, w);
        end
        settings_used++;
    endtask

    // Hold until every word is sent and every command is back, then let it settle;
    // look between edges so the driver and monitor updates have all landed
    task automatic wait_idle();
        do @(negedge i_clk);
        while (chars_pending.size() != 0 || char_ch.valid || draws_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        int sent;
        int phase_len;

        char_ch.valid     = 1'b0;
        char_ch.char_code = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        draw_ch.ready     = 1'b0;
        i_rst_n           = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset size: glyph extremes, clear, backspace at line start, tab, CR, LF
        chars_pending = '{8'h41, 8'h00, 8'hFF, 8'h80, 8'h7F, CH_BACKSPACE, CH_TAB,
                          CH_BACKSPACE, CH_RETURN, CH_BACKSPACE, CH_NEWLINE, 8'h20};
        wait_idle();

        // Screen of one cell: glyphs and tabs wrap and scroll, LF scrolls, row held at 0
        set_screen(DIM_W'(8), DIM_W'(16));
        chars_pending = '{8'h5A, CH_NEWLINE, CH_TAB, CH_BACKSPACE};
        wait_idle();

        // Oversized registers act as the cap
        set_screen(DIM_W'(8191), DIM_W'(8191));
        chars_pending = '{8'h61, CH_TAB, CH_NEWLINE};
        wait_idle();

        set_screen(DIM_W'(0), DIM_W'(0));
        chars_pending = '{8'h62, CH_RETURN};
        wait_idle();

        set_screen(DIM_W'(4096), DIM_W'(4096));
        chars_pending = '{8'h63, CH_BACKSPACE};
        wait_idle();

        // Random phases; the cursor carries over so new sizes hit it mid-screen
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            set_screen(pick_dim(), pick_dim());
            steady    = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(40, 160);
            repeat (phase_len) chars_pending.push_back(pick_char());
            sent += phase_len;
            wait_idle();
            steady = 1'b0;
        end

        repeat (8) @(posedge i_clk);
        $display("Covered %0d characters under %0d screen settings, %0d commands checked.",
                 chars_taken, settings_used, cmds_seen);
        $display("Seen %0d glyph draws, %0d cell clears and %0d scroll requests.",
                 glyphs, clears, scrolls);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
